// ===== design/csvt_pkg.sv =====
`timescale 1ns / 1ps

package csvt_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_FIELDS_DEF = 1024;
    localparam int LINE_BITS_DEF  = 32;

    // Fixed field and register widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 24;
    localparam int ERR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] DELIM_RST   = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RST   = 8'd34;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 24'hFF_FFFF;

    // Special bytes
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

    // Error flag bit positions
    localparam int ERR_NULL      = 0;
    localparam int ERR_QUOTE     = 1;
    localparam int ERR_AFTER_Q   = 2;
    localparam int ERR_TOO_LONG  = 3;
    localparam int ERR_COUNT     = 4;
    localparam int ERR_MIXED_EOL = 5;
    localparam int ERR_UNCLOSED  = 6;
    localparam int ERR_EMPTY_HDR = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] delim;
        logic [BYTE_W-1:0] quote;
        logic [LEN_W-1:0]  max_len;
        logic              has_header;
    } t_cfg;

    // Write of the header register, seen by the scanner for the first-byte rule
    typedef struct packed {
        logic we;
        logic val;
    } t_hdr_wr;

endpackage

// ===== design/csvt_cfg.sv =====
`timescale 1ns / 1ps

module csvt_cfg
    import csvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output t_hdr_wr               o_hdr_wr
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim      <= DELIM_RST;
            r_cfg.quote      <= QUOTE_RST;
            r_cfg.max_len    <= MAX_LEN_RST;
            r_cfg.has_header <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DELIM:   r_cfg.delim      <= i_cfg_data[BYTE_W-1:0];
                REG_QUOTE:   r_cfg.quote      <= i_cfg_data[BYTE_W-1:0];
                REG_MAX_LEN: r_cfg.max_len    <= i_cfg_data[LEN_W-1:0];
                REG_HEADER:  r_cfg.has_header <= i_cfg_data[0];
                default:     r_cfg            <= r_cfg;
            endcase
        end
    end

    assign o_cfg       = r_cfg;
    assign o_hdr_wr.we  = i_cfg_we && (i_cfg_idx == REG_HEADER);
    assign o_hdr_wr.val = i_cfg_data[0];

endmodule

// ===== design/csvt_in_reg.sv =====
`timescale 1ns / 1ps

module csvt_in_reg
    import csvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eoi,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_eoi,
    input  logic              i_take
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eoi;

    // Refill whenever empty or the held beat moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eoi  <= i_eoi;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eoi   = r_eoi;

endmodule

// ===== design/csvt_core.sv =====
`timescale 1ns / 1ps

module csvt_core
    import csvt_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF,
    localparam int FIELD_W   = $clog2(MAX_FIELDS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_hdr_wr              i_hdr_wr,
    input  logic                 i_valid,
    input  logic [BYTE_W-1:0]    i_byte,
    input  logic                 i_eoi,
    output logic                 o_take,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BYTE_W-1:0]    o_byte,
    output logic                 o_byte_valid,
    output logic                 o_field_end,
    output logic                 o_row_end,
    output logic                 o_is_header,
    output logic [FIELD_W-1:0]   o_fields_in_row,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic [ERR_W-1:0]     o_error_flags
);

    localparam logic [2:0] ST_RECORD      = 3'd0;
    localparam logic [2:0] ST_FIELD       = 3'd1;
    localparam logic [2:0] ST_UNQUOTED    = 3'd2;
    localparam logic [2:0] ST_QUOTED      = 3'd3;
    localparam logic [2:0] ST_AFTER_QUOTE = 3'd4;

    localparam logic [1:0] END_UNKNOWN = 2'd0;
    localparam logic [1:0] END_LF      = 2'd1;
    localparam logic [1:0] END_CR      = 2'd2;
    localparam logic [1:0] END_CRLF    = 2'd3;

    localparam logic [FIELD_W-1:0]   FIELDS_TOP = FIELD_W'(MAX_FIELDS);
    localparam logic [LINE_BITS-1:0] LINE_TOP   = '1;
    localparam logic [LEN_W-1:0]     LEN_TOP    = '1;

    // Scan state
    logic [2:0]           r_state,   n_state;
    logic                 r_in_hdr,  n_in_hdr;
    logic                 r_first,   n_first;
    logic [LEN_W-1:0]     r_len,     n_len;
    logic [FIELD_W-1:0]   r_cnt,     n_cnt;
    logic [FIELD_W-1:0]   r_exp,     n_exp;
    logic [LINE_BITS-1:0] r_row,     n_row;
    logic [1:0]           r_kind,    n_kind;
    logic                 r_warned,  n_warned;
    logic                 r_pend,    n_pend;

    // Result register
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_ob;
    logic                 r_bv, r_fe, r_re, r_hdr;
    logic [FIELD_W-1:0]   r_fields;
    logic [LINE_BITS-1:0] r_line;
    logic [ERR_W-1:0]     r_err;

    // Next result
    logic [BYTE_W-1:0]    n_ob;
    logic                 n_bv, n_fe, n_re, n_hdr;
    logic [FIELD_W-1:0]   n_fields;
    logic [ERR_W-1:0]     n_err;

    logic [FIELD_W-1:0]   cnt_inc;
    logic [LINE_BITS-1:0] row_inc;
    logic                 is_quote, is_delim, is_nl, done, append, row_done;

    assign o_take  = i_valid && (!r_out_valid || i_ready);
    assign cnt_inc = (r_cnt < FIELDS_TOP) ? r_cnt + 1'b1 : r_cnt;
    assign row_inc = (r_row != LINE_TOP) ? r_row + 1'b1 : r_row;
    assign is_quote = (i_byte == i_cfg.quote);
    assign is_delim = (i_byte == i_cfg.delim);
    assign is_nl    = (i_byte == CH_LF) || (i_byte == CH_CR);

    always_comb begin
        n_state  = r_state;
        n_in_hdr = r_in_hdr;
        n_first  = r_first;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        n_row    = r_row;
        n_kind   = r_kind;
        n_warned = r_warned;
        n_pend   = r_pend;
        n_ob     = '0;
        n_bv     = 1'b0;
        n_fe     = 1'b0;
        n_re     = 1'b0;
        n_err    = '0;
        done     = 1'b0;
        append   = 1'b0;
        row_done = 1'b0;
        n_hdr    = r_in_hdr;

        // Resolve a pending CR first; an LF right after it is swallowed
        if (r_pend) begin
            n_pend = 1'b0;
            if (r_in_hdr) begin
                n_in_hdr = 1'b0;
                n_hdr    = 1'b1;
            end else begin
                n_hdr = 1'b0;
                if (n_kind == END_UNKNOWN) begin
                    n_kind = (!i_eoi && i_byte == CH_LF) ? END_CRLF : END_CR;
                end else if (n_kind != ((!i_eoi && i_byte == CH_LF) ? END_CRLF : END_CR)
                             && !n_warned) begin
                    n_err[ERR_MIXED_EOL] = 1'b1;
                    n_warned             = 1'b1;
                end
            end
            done = !i_eoi && (i_byte == CH_LF);
        end
        if (!done) begin
            n_hdr = n_in_hdr;
        end

        if (done) begin
            n_hdr = n_hdr;
        end else if (i_eoi) begin
            if (n_in_hdr) begin
                if (!r_first) begin
                    if (r_state == ST_QUOTED) begin
                        n_err[ERR_UNCLOSED] = 1'b1;
                    end else begin
                        n_fe = 1'b1;
                        n_re = 1'b1;
                    end
                end
            end else if (r_state != ST_RECORD) begin
                if (r_state == ST_QUOTED) begin
                    n_err[ERR_UNCLOSED] = 1'b1;
                end
                n_fe = 1'b1;
                n_re = 1'b1;
                if (r_exp != '0 && cnt_inc != r_exp) begin
                    n_err[ERR_COUNT] = 1'b1;
                end
            end
            // Return to the start of a new stream, registers kept
            n_state  = ST_RECORD;
            n_in_hdr = i_cfg.has_header;
            n_first  = 1'b1;
            n_len    = '0;
            n_cnt    = '0;
            n_exp    = '0;
            n_row    = LINE_BITS'(1);
            n_kind   = END_UNKNOWN;
            n_warned = 1'b0;
            n_pend   = 1'b0;
        end else if (i_byte == CH_NUL) begin
            n_first            = 1'b0;
            n_err[ERR_NULL]    = 1'b1;
        end else if (n_in_hdr && r_first && is_nl) begin
            n_first              = 1'b0;
            n_err[ERR_EMPTY_HDR] = 1'b1;
            n_row                = row_inc;
            if (i_byte == CH_CR) begin
                n_pend = 1'b1;
            end else begin
                n_in_hdr = 1'b0;
            end
        end else begin
            n_first = 1'b0;
            case (r_state)
                ST_UNQUOTED: begin
                    if (is_quote) begin
                        n_err[ERR_QUOTE] = 1'b1;
                        append           = 1'b1;
                    end else if (is_delim) begin
                        n_fe    = 1'b1;
                        n_state = ST_FIELD;
                    end else if (is_nl) begin
                        row_done = 1'b1;
                    end else begin
                        append = 1'b1;
                    end
                end
                ST_QUOTED: begin
                    if (is_quote) begin
                        n_state = ST_AFTER_QUOTE;
                    end else begin
                        append = 1'b1;
                    end
                end
                ST_AFTER_QUOTE: begin
                    if (is_quote) begin
                        append  = 1'b1;
                        n_state = ST_QUOTED;
                    end else if (is_delim) begin
                        n_fe    = 1'b1;
                        n_state = ST_FIELD;
                    end else if (is_nl) begin
                        row_done = 1'b1;
                    end else begin
                        n_err[ERR_AFTER_Q] = 1'b1;
                        append             = 1'b1;
                        n_state            = ST_UNQUOTED;
                    end
                end
                default: begin
                    if (is_quote) begin
                        n_state = ST_QUOTED;
                    end else if (is_delim) begin
                        n_fe    = 1'b1;
                        n_state = ST_FIELD;
                    end else if (is_nl) begin
                        row_done = 1'b1;
                    end else begin
                        append  = 1'b1;
                        n_state = ST_UNQUOTED;
                    end
                end
            endcase

            if (append) begin
                n_len = (r_len != LEN_TOP) ? r_len + 1'b1 : r_len;
                n_ob  = i_byte;
                n_bv  = 1'b1;
            end
            if (n_fe) begin
                n_cnt = cnt_inc;
                n_len = '0;
            end

            if (row_done) begin
                n_fe = 1'b1;
                n_re = 1'b1;
                if (n_hdr) begin
                    n_exp = cnt_inc;
                    if (i_byte == CH_CR) begin
                        n_pend = 1'b1;
                    end else begin
                        n_in_hdr = 1'b0;
                    end
                end else begin
                    if (r_exp != '0 && cnt_inc != r_exp) begin
                        n_err[ERR_COUNT] = 1'b1;
                    end
                    if (i_byte == CH_LF) begin
                        if (n_kind == END_UNKNOWN) begin
                            n_kind = END_LF;
                        end else if (n_kind != END_LF && !n_warned) begin
                            n_err[ERR_MIXED_EOL] = 1'b1;
                            n_warned             = 1'b1;
                        end
                    end else begin
                        n_pend = 1'b1;
                    end
                end
                n_row   = row_inc;
                n_cnt   = '0;
                n_len   = '0;
                n_state = ST_RECORD;
            end else if (!n_hdr && n_len > i_cfg.max_len) begin
                n_err[ERR_TOO_LONG] = 1'b1;
            end
        end

        n_fields = n_fe ? cnt_inc : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RECORD;
            r_in_hdr <= 1'b0;
            r_first  <= 1'b1;
            r_len    <= '0;
            r_cnt    <= '0;
            r_exp    <= '0;
            r_row    <= LINE_BITS'(1);
            r_kind   <= END_UNKNOWN;
            r_warned <= 1'b0;
            r_pend   <= 1'b0;
        end else if (o_take) begin
            r_state  <= n_state;
            r_in_hdr <= n_in_hdr;
            r_first  <= n_first;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_exp    <= n_exp;
            r_row    <= n_row;
            r_kind   <= n_kind;
            r_warned <= n_warned;
            r_pend   <= n_pend;
        end else if (i_hdr_wr.we && r_first) begin
            r_in_hdr <= i_hdr_wr.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ob     <= n_ob;
            r_bv     <= n_bv;
            r_fe     <= n_fe;
            r_re     <= n_re;
            r_hdr    <= n_hdr;
            r_fields <= n_fields;
            r_line   <= r_row;
            r_err    <= n_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte          = r_ob;
    assign o_byte_valid    = r_bv;
    assign o_field_end     = r_fe;
    assign o_row_end       = r_re;
    assign o_is_header     = r_hdr;
    assign o_fields_in_row = r_fields;
    assign o_line_number   = r_line;
    assign o_error_flags   = r_err;

endmodule

// ===== design/csv_byte_tokenizer.sv =====
`timescale 1ns / 1ps

// CSV byte tokenizer.
// Input channel (i_in_valid / o_in_ready): one beat is a raw CSV byte on
// i_in_byte, or an end-of-input marker when i_end_of_input is high.
// Output channel (o_out_valid / i_out_ready): exactly one result beat per
// input beat, in order: content byte with byte_valid, field and row end
// marks, header flag, field count so far, line number and error flags.
// Configuration: i_cfg_we writes register i_cfg_idx (0 delimiter, 1 quote,
// 2 max field bytes, 3 header row enable) with no wait; write only while idle.
// Path from input accept to result valid: input register, then scan logic
// into the result register.
// Throughput: one beat per cycle while the receiver keeps up; the quoting
// state update is a combinational case between the input and result registers.
// Reset (synchronous, i_rst_n low) restores register defaults, clears both
// pipeline registers and returns the scanner to the start of a stream.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and o_in_ready drops until the result is taken.
// An end-of-input beat also returns the scanner to the start of a stream.
module csv_byte_tokenizer
    import csvt_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF,
    localparam int FIELD_W   = $clog2(MAX_FIELDS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beat
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_in_byte,
    input  logic                  i_end_of_input,
    // result beat
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_field_end,
    output logic                  o_row_end,
    output logic                  o_is_header,
    output logic [FIELD_W-1:0]    o_fields_in_row,
    output logic [LINE_BITS-1:0]  o_line_number,
    output logic [ERR_W-1:0]      o_error_flags
);

    t_cfg              cfg;
    t_hdr_wr           hdr_wr;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_eoi;
    logic              take;

    // Register file for delimiter, quote, length limit and header enable
    csvt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_hdr_wr   (hdr_wr)
    );

    // Input register: take a beat whenever empty or the held one advances
    csvt_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_in_byte),
        .i_eoi   (i_end_of_input),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_eoi   (in_eoi),
        .i_take  (take)
    );

    // Scanner state plus result register; advance when the result slot frees
    csvt_core #(
        .MAX_FIELDS (MAX_FIELDS),
        .LINE_BITS  (LINE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_hdr_wr        (hdr_wr),
        .i_valid         (in_valid),
        .i_byte          (in_byte),
        .i_eoi           (in_eoi),
        .o_take          (take),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_byte          (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_field_end     (o_field_end),
        .o_row_end       (o_row_end),
        .o_is_header     (o_is_header),
        .o_fields_in_row (o_fields_in_row),
        .o_line_number   (o_line_number),
        .o_error_flags   (o_error_flags)
    );

endmodule

// ===== design/csvt_checker.sv =====
`timescale 1ns / 1ps

module csvt_checker
    import csvt_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF,
    localparam int FIELD_W   = $clog2(MAX_FIELDS + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [BYTE_W-1:0]     o_out_byte,
    input logic                  o_byte_valid,
    input logic                  o_field_end,
    input logic                  o_row_end,
    input logic [FIELD_W-1:0]    o_fields_in_row
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A row end always closes a field as well
    a_row_has_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_end |-> o_field_end)
        else $error("row end without field end");

    // A content byte never closes a field
    a_byte_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> !o_field_end)
        else $error("content byte with field end");

    // Non-content beats carry a zero byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_out_byte == '0)
        else $error("nonzero byte without byte_valid");

    // Field count saturates at the configured maximum
    a_fields_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fields_in_row <= FIELD_W'(MAX_FIELDS))
        else $error("field count above maximum");

endmodule

bind csv_byte_tokenizer csvt_checker #(
    .MAX_FIELDS (MAX_FIELDS),
    .LINE_BITS  (LINE_BITS)
) u_csvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_field_end     (o_field_end),
    .o_row_end       (o_row_end),
    .o_fields_in_row (o_fields_in_row)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the CSV byte tokenizer: a directed table first, then
// random CSV streams under changing delimiter, quote, length limit and header
// settings. Each accepted input beat runs through a local tokenizer model, and
// its result, or a hand-written one, is queued and compared with the next result beat of the block.
module testbench;
    import csvt_pkg::*;

    localparam int FIELD_W    = $clog2(MAX_FIELDS_DEF + 1);
    localparam int LINE_W     = LINE_BITS_DEF;
    localparam int CYCLE_CAP  = 100000;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_BEATS = 950;

    typedef enum logic [2:0] {
        SCAN_RECORD, SCAN_FIELD, SCAN_UNQUOTED, SCAN_QUOTED, SCAN_AFTER_Q
    } scan_e;

    typedef enum logic [1:0] {EOL_NONE, EOL_LF, EOL_CR, EOL_CRLF} eol_e;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               field_end;
        logic               row_end;
        logic               is_header;
        logic [FIELD_W-1:0] fields;
        logic [LINE_W-1:0]  line;
        logic [ERR_W-1:0]   err;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eoi;
        logic              typed;   // use the hand-written result instead of the model
        token_t            want;
    } csv_beat_t;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        csv_beat_t             beat;
    } dir_row_t;

    // Clock, reset and block ports
    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     in_byte;
    logic                  in_eoi;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     out_byte;
    logic                  out_byte_valid;
    logic                  out_field_end;
    logic                  out_row_end;
    logic                  out_is_header;
    logic [FIELD_W-1:0]    out_fields;
    logic [LINE_W-1:0]     out_line;
    logic [ERR_W-1:0]      out_err;

    // Bench bookkeeping
    csv_beat_t csv_q[$];      // beats waiting to be offered
    token_t    token_q[$];    // results owed by the block, oldest first
    dir_row_t  dir_tab[$];
    bit        rst_done   = 1'b0;
    bit        feeding    = 1'b0;
    bit        no_gaps    = 1'b0;
    bit        long_stall = 1'b0;
    int        bad_beats  = 0;
    int        queued     = 0;
    int        cycles     = 0;

    // Model copy of the registers
    logic [BYTE_W-1:0] cfg_delim;
    logic [BYTE_W-1:0] cfg_quote;
    logic [LEN_W-1:0]  cfg_max_len;
    logic              cfg_hdr;

    // Model copy of the scanner state
    scan_e              scan;
    logic               in_hdr;
    logic               first_byte;
    logic [LEN_W-1:0]   fld_len;
    logic [FIELD_W-1:0] row_fields;
    logic [FIELD_W-1:0] want_fields;
    logic [LINE_W-1:0]  row_num;
    eol_e               first_eol;
    logic               eol_warned;
    logic               cr_held;

    csv_byte_tokenizer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_end_of_input  (in_eoi),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_byte      (out_byte),
        .o_byte_valid    (out_byte_valid),
        .o_field_end     (out_field_end),
        .o_row_end       (out_row_end),
        .o_is_header     (out_is_header),
        .o_fields_in_row (out_fields),
        .o_line_number   (out_line),
        .o_error_flags   (out_err)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: stop a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tokenizer model
    // ---------------------------------------------------------------------

    // Return the scanner to the start of a stream; registers stay.
    function automatic void restart_stream();
        scan        = SCAN_RECORD;
        in_hdr      = cfg_hdr;
        first_byte  = 1'b1;
        fld_len     = '0;
        row_fields  = '0;
        want_fields = '0;
        row_num     = 1;
        first_eol   = EOL_NONE;
        eol_warned  = 1'b0;
        cr_held     = 1'b0;
    endfunction

    function automatic void reset_model();
        cfg_delim   = DELIM_RST;
        cfg_quote   = QUOTE_RST;
        cfg_max_len = MAX_LEN_RST;
        cfg_hdr     = 1'b0;
        restart_stream();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DELIM:   cfg_delim   = val[BYTE_W-1:0];
            REG_QUOTE:   cfg_quote   = val[BYTE_W-1:0];
            REG_MAX_LEN: cfg_max_len = val[LEN_W-1:0];
            default: begin
                cfg_hdr = val[0];
                // Before the first byte the header setting applies at once
                if (first_byte)
                    in_hdr = cfg_hdr;
            end
        endcase
    endfunction

    // Track the ending style of data rows; flag the first disagreement once.
    function automatic logic eol_clash(input eol_e kind);
        if (first_eol == EOL_NONE) begin
            first_eol = kind;
            return 1'b0;
        end
        if (kind != first_eol && !eol_warned) begin
            eol_warned = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void close_field();
        if (row_fields < MAX_FIELDS_DEF)
            row_fields = row_fields + 1'b1;
        fld_len = '0;
    endfunction

    function automatic void bump_row();
        if (row_num != '1)
            row_num = row_num + 1'b1;
    endfunction

    // Work out the result beat for one input beat and advance the model.
    function automatic token_t tokenize_beat(input logic [BYTE_W-1:0] c, input logic eoi);
        token_t t;
        logic   lf;
        logic   nl;
        logic   add;
        logic   row_done;
        logic   swallowed;
        logic   hdr;
        t         = '0;
        add       = 1'b0;
        row_done  = 1'b0;
        swallowed = 1'b0;
        hdr       = 1'b0;
        // A held CR is settled by whatever comes next
        if (cr_held) begin
            lf      = !eoi && (c == CH_LF);
            cr_held = 1'b0;
            if (in_hdr) begin
                in_hdr = 1'b0;
                hdr    = 1'b1;
            end else if (eol_clash(lf ? EOL_CRLF : EOL_CR)) begin
                t.err[ERR_MIXED_EOL] = 1'b1;
            end
            swallowed = lf;
        end
        if (!swallowed)
            hdr = in_hdr;
        t.is_header = hdr;
        t.line      = row_num;
        t.fields    = row_fields;

        if (swallowed) begin
            // LF of a CRLF pair: nothing else happens
        end else if (eoi) begin
            if (in_hdr) begin
                if (!first_byte) begin
                    if (scan == SCAN_QUOTED) begin
                        t.err[ERR_UNCLOSED] = 1'b1;
                    end else begin
                        close_field();
                        t.field_end = 1'b1;
                        t.row_end   = 1'b1;
                        want_fields = row_fields;
                    end
                end
            end else if (scan != SCAN_RECORD) begin
                if (scan == SCAN_QUOTED)
                    t.err[ERR_UNCLOSED] = 1'b1;
                close_field();
                t.field_end = 1'b1;
                t.row_end   = 1'b1;
                if (want_fields != 0 && row_fields != want_fields)
                    t.err[ERR_COUNT] = 1'b1;
            end
            t.fields = row_fields;
            restart_stream();
        end else if (c == CH_NUL) begin
            first_byte       = 1'b0;
            t.err[ERR_NULL] = 1'b1;
        end else if (in_hdr && first_byte && (c == CH_LF || c == CH_CR)) begin
            first_byte           = 1'b0;
            t.err[ERR_EMPTY_HDR] = 1'b1;
            bump_row();
            if (c == CH_CR)
                cr_held = 1'b1;
            else
                in_hdr = 1'b0;
        end else begin
            nl         = (c == CH_LF) || (c == CH_CR);
            first_byte = 1'b0;
            // Quote wins over delimiter, delimiter over line endings
            case (scan)
                SCAN_UNQUOTED: begin
                    if (c == cfg_quote) begin
                        t.err[ERR_QUOTE] = 1'b1;
                        add              = 1'b1;
                    end else if (c == cfg_delim) begin
                        close_field();
                        t.field_end = 1'b1;
                        scan        = SCAN_FIELD;
                    end else if (nl) begin
                        row_done = 1'b1;
                    end else begin
                        add = 1'b1;
                    end
                end
                SCAN_QUOTED: begin
                    if (c == cfg_quote)
                        scan = SCAN_AFTER_Q;
                    else
                        add = 1'b1;
                end
                SCAN_AFTER_Q: begin
                    if (c == cfg_quote) begin
                        add  = 1'b1;
                        scan = SCAN_QUOTED;
                    end else if (c == cfg_delim) begin
                        close_field();
                        t.field_end = 1'b1;
                        scan        = SCAN_FIELD;
                    end else if (nl) begin
                        row_done = 1'b1;
                    end else begin
                        t.err[ERR_AFTER_Q] = 1'b1;
                        add                = 1'b1;
                        scan               = SCAN_UNQUOTED;
                    end
                end
                default: begin
                    if (c == cfg_quote) begin
                        scan = SCAN_QUOTED;
                    end else if (c == cfg_delim) begin
                        close_field();
                        t.field_end = 1'b1;
                        scan        = SCAN_FIELD;
                    end else if (nl) begin
                        row_done = 1'b1;
                    end else begin
                        add  = 1'b1;
                        scan = SCAN_UNQUOTED;
                    end
                end
            endcase
            if (add) begin
                if (fld_len != '1)
                    fld_len = fld_len + 1'b1;
                t.out_byte   = c;
                t.byte_valid = 1'b1;
            end
            if (row_done) begin
                close_field();
                t.field_end = 1'b1;
                t.row_end   = 1'b1;
                t.fields    = row_fields;
                if (hdr) begin
                    want_fields = row_fields;
                    if (c == CH_CR)
                        cr_held = 1'b1;
                    else
                        in_hdr = 1'b0;
                end else begin
                    if (want_fields != 0 && row_fields != want_fields)
                        t.err[ERR_COUNT] = 1'b1;
                    if (c == CH_LF) begin
                        if (eol_clash(EOL_LF))
                            t.err[ERR_MIXED_EOL] = 1'b1;
                    end else begin
                        cr_held = 1'b1;
                    end
                end
                bump_row();
                row_fields = '0;
                scan       = SCAN_RECORD;
            end else begin
                if (!hdr && fld_len > cfg_max_len)
                    t.err[ERR_TOO_LONG] = 1'b1;
                t.fields = row_fields;
            end
        end
        return t;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic dir_row_t step_byte(input logic [BYTE_W-1:0] b);
        dir_row_t r;
        r           = '0;
        r.kind      = ROW_BEAT;
        r.beat.data = b;
        return r;
    endfunction

    function automatic dir_row_t step_end();
        dir_row_t r;
        r          = '0;
        r.kind     = ROW_BEAT;
        r.beat.eoi = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t step_fixed(input logic [BYTE_W-1:0] b, input logic eoi,
                                            input token_t want);
        dir_row_t r;
        r            = '0;
        r.kind       = ROW_BEAT;
        r.beat.data  = b;
        r.beat.eoi   = eoi;
        r.beat.typed = 1'b1;
        r.beat.want  = want;
        return r;
    endfunction

    function automatic dir_row_t step_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] d);
        csv_beat_t b;
        b      = '0;
        b.data = d;
        csv_q.push_back(b);
        queued++;
    endfunction

    function automatic void queue_end();
        csv_beat_t b;
        b     = '0;
        b.eoi = 1'b1;
        csv_q.push_back(b);
        queued++;
    endfunction

    // Mostly letters and digits, now and then a null or any byte at all
    function automatic logic [BYTE_W-1:0] text_byte();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return BYTE_W'($urandom_range(0, 255));
        if (r == 1)
            return CH_NUL;
        if (r < 24)
            return BYTE_W'($urandom_range(97, 122));
        return BYTE_W'($urandom_range(48, 57));
    endfunction

    function automatic void queue_eol(input eol_e kind);
        if (kind == EOL_LF) begin
            queue_byte(CH_LF);
        end else if (kind == EOL_CRLF) begin
            queue_byte(CH_CR);
            queue_byte(CH_LF);
        end else begin
            queue_byte(CH_CR);
        end
    endfunction

    function automatic void queue_field();
        int n;
        case ($urandom_range(0, 5))
            0: ;  // empty field
            1, 2, 3: begin
                n = $urandom_range(1, 6);
                repeat (n) queue_byte(text_byte());
            end
            default: begin
                queue_byte(cfg_quote);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            queue_byte(cfg_quote);
                            queue_byte(cfg_quote);
                        end
                        1: queue_byte(cfg_delim);
                        2: queue_byte(CH_LF);
                        default: queue_byte(text_byte());
                    endcase
                end
                queue_byte(cfg_quote);
                // junk after the closing quote
                if ($urandom_range(0, 7) == 0)
                    queue_byte(text_byte());
            end
        endcase
    endfunction

    // One stream of rows with a mostly steady shape, then a way to finish it
    function automatic void queue_stream();
        int   rows;
        int   cols;
        int   nf;
        eol_e eol;
        rows = $urandom_range(2, 6);
        cols = $urandom_range(1, 4);
        eol  = eol_e'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0)
            queue_end();
        if (cfg_hdr && $urandom_range(0, 5) == 0)
            queue_eol(eol_e'($urandom_range(1, 3)));
        repeat (rows) begin
            nf = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : cols;
            for (int f = 0; f < nf; f++) begin
                queue_field();
                if (f < nf - 1)
                    queue_byte(cfg_delim);
            end
            if ($urandom_range(0, 15) == 0)
                queue_byte(BYTE_W'($urandom_range(0, 255)));
            queue_eol(($urandom_range(0, 9) == 0) ? eol_e'($urandom_range(1, 3)) : eol);
        end
        case ($urandom_range(0, 9))
            0: begin
                // stream ends inside a quoted field
                queue_byte(cfg_quote);
                queue_byte(text_byte());
                queue_end();
            end
            1: ;  // leave the stream open into the next phase
            2: begin
                // last row without an ending
                queue_field();
                queue_end();
            end
            default: queue_end();
        endcase
    endfunction

    // Wait until every beat is offered and every result is back, then let
    // the pipeline drain.
    task automatic settle();
        while (csv_q.size() != 0 || feeding || token_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write, with an idle wait after the enable drops so back-to-back
    // writes never touch the write enable twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, val);
        @(negedge clk);
    endtask

    function automatic string show(input token_t t);
        return $sformatf("byte=%h bv=%b fe=%b re=%b hdr=%b fields=%0d line=%0d err=%h",
                         t.out_byte, t.byte_valid, t.field_end, t.row_end,
                         t.is_header, t.fields, t.line, t.err);
    endfunction

    // ---------------------------------------------------------------------
    // Input side: offer beats, hold valid and payload until accepted
    // ---------------------------------------------------------------------
    initial begin : feed
        csv_beat_t b;
        int        gap;
        while (!rst_done) @(negedge clk);
        forever begin
            if (csv_q.size() == 0) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end else begin
                b       = csv_q.pop_front();
                feeding = 1'b1;
                gap     = pick_gap();
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                in_valid <= 1'b1;
                in_byte  <= b.data;
                in_eoi   <= b.eoi;
                @(posedge clk);
                while (!in_ready) @(posedge clk);
                // Beat accepted: predict its result now, in order
                if (b.typed) begin
                    void'(tokenize_beat(b.data, b.eoi));
                    token_q.push_back(b.want);
                end else begin
                    token_q.push_back(tokenize_beat(b.data, b.eoi));
                end
                @(negedge clk);
                feeding = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request, and checks
    // ---------------------------------------------------------------------
    initial begin : drain
        int     hold;
        token_t got;
        token_t want;
        while (!rst_done) @(negedge clk);
        forever begin
            if (long_stall) begin
                // Hold off long enough for the block to fill and stall its input
                long_stall = 1'b0;
                hold       = LONG_HOLD;
            end else begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got = {out_byte, out_byte_valid, out_field_end, out_row_end, out_is_header,
                   out_fields, out_line, out_err};
            if (token_q.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected result beat: %s", show(got));
            end else begin
                want = token_q.pop_front();
                if (got !== want) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 show(want), show(got));
                end
            end
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: reset, directed table, random phases, wind-down
    // ---------------------------------------------------------------------
    initial begin : run
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] q;
        logic [LEN_W-1:0]  m;
        int                phase;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_DELIM;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        in_eoi    <= 1'b0;
        out_ready <= 1'b0;
        reset_model();

        // Default settings: plain text, null, escapes and quote errors,
        // CRLF then LF (mixed endings), a lone CR, an unclosed quote at the end
        dir_tab.push_back(step_fixed("a", 1'b0,
            '{"a", 1'b1, 1'b0, 1'b0, 1'b0, FIELD_W'(0), LINE_W'(1), ERR_W'(0)}));
        dir_tab.push_back(step_fixed(CH_NUL, 1'b0,
            '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, FIELD_W'(0), LINE_W'(1),
              ERR_W'(1 << ERR_NULL)}));
        dir_tab.push_back(step_byte(DELIM_RST));
        repeat (4) dir_tab.push_back(step_byte(QUOTE_RST));
        dir_tab.push_back(step_byte("y"));
        dir_tab.push_back(step_byte(QUOTE_RST));
        dir_tab.push_back(step_byte(CH_CR));
        dir_tab.push_back(step_byte(CH_LF));
        dir_tab.push_back(step_byte(CH_LF));
        dir_tab.push_back(step_byte(CH_CR));
        dir_tab.push_back(step_byte(QUOTE_RST));
        dir_tab.push_back(step_end());
        // End of input with nothing open: no row, no flags
        dir_tab.push_back(step_fixed(8'h00, 1'b1,
            '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, FIELD_W'(0), LINE_W'(1), ERR_W'(0)}));
        // Header on, tight length limit: empty header line, then an overlong field
        dir_tab.push_back(step_reg(REG_HEADER, 1));
        dir_tab.push_back(step_reg(REG_MAX_LEN, 1));
        dir_tab.push_back(step_reg(REG_DELIM, ";"));
        dir_tab.push_back(step_fixed(CH_LF, 1'b0,
            '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, FIELD_W'(0), LINE_W'(1),
              ERR_W'(1 << ERR_EMPTY_HDR)}));
        dir_tab.push_back(step_byte("i"));
        dir_tab.push_back(step_byte("j"));
        dir_tab.push_back(step_end());
        // Two-field header closed by CRLF, then a one-field data row
        dir_tab.push_back(step_byte("h"));
        dir_tab.push_back(step_byte(";"));
        dir_tab.push_back(step_byte("i"));
        dir_tab.push_back(step_byte(CH_CR));
        dir_tab.push_back(step_byte(CH_LF));
        dir_tab.push_back(step_byte("k"));
        dir_tab.push_back(step_byte(CH_LF));
        dir_tab.push_back(step_end());

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n    <= 1'b1;
        rst_done  = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                csv_q.push_back(dir_tab[i].beat);
            end
        end

        // Random phases: new settings while idle, then one or two streams
        queued = 0;
        phase  = 0;
        while (queued < RAND_BEATS) begin
            settle();
            case (phase % 4)
                1: begin
                    // extreme values for the separators, zero length limit
                    d = 8'hFF;
                    q = 8'h00;
                    m = '0;
                end
                3: begin
                    d = 8'h01;
                    q = 8'hFF;
                    m = '1;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: d = DELIM_RST;
                        1: d = ";";
                        2: d = 8'h09;
                        3: d = "|";
                        default: d = BYTE_W'($urandom_range(1, 255));
                    endcase
                    case ($urandom_range(0, 3))
                        0, 1: q = QUOTE_RST;
                        2: q = "'";
                        default: q = BYTE_W'($urandom_range(0, 255));
                    endcase
                    case ($urandom_range(0, 3))
                        0: m = LEN_W'($urandom_range(0, 3));
                        1: m = LEN_W'($urandom_range(2, 12));
                        2: m = MAX_LEN_RST;
                        default: m = LEN_W'($urandom_range(0, 16777215));
                    endcase
                end
            endcase
            write_reg(REG_DELIM, CFG_DATA_W'(d));
            write_reg(REG_QUOTE, CFG_DATA_W'(q));
            write_reg(REG_MAX_LEN, CFG_DATA_W'(m));
            write_reg(REG_HEADER, CFG_DATA_W'($urandom_range(0, 1)));
            // every third phase runs with no gaps on either side
            no_gaps = (phase % 3 == 2);
            if (phase == 3)
                long_stall = 1'b1;
            queue_stream();
            if ($urandom_range(0, 1) == 1)
                queue_stream();
            phase++;
        end

        settle();
        no_gaps = 1'b0;
        repeat (8) @(posedge clk);
        if (bad_beats == 0 && token_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== csv_byte_tokenizer.f =====
design/csvt_pkg.sv
design/csvt_cfg.sv
design/csvt_in_reg.sv
design/csvt_core.sv
design/csv_byte_tokenizer.sv
design/csvt_checker.sv
tb/testbench.sv
